>>> rtl/compass_heading_from_calibrated_field_defines.svh
// Assertion macros shared by the compass heading block.
`ifndef COMPASS_HEADING_FROM_CALIBRATED_FIELD_DEFINES_SVH
`define COMPASS_HEADING_FROM_CALIBRATED_FIELD_DEFINES_SVH

// Check cond at every clock edge outside reset.
`define CHFC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that ante implies cons in the same cycle.
`define CHFC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/chfc_pkg.sv
package chfc_pkg;

    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 17;

    localparam logic [CfgIndexW-1:0] REG_OFFSET_X  = 3'd0;
    localparam logic [CfgIndexW-1:0] REG_OFFSET_Y  = 3'd1;
    localparam logic [CfgIndexW-1:0] REG_OFFSET_Z  = 3'd2;
    localparam logic [CfgIndexW-1:0] REG_GAIN_X    = 3'd3;
    localparam logic [CfgIndexW-1:0] REG_GAIN_Y    = 3'd4;
    localparam logic [CfgIndexW-1:0] REG_GAIN_Z    = 3'd5;
    localparam logic [CfgIndexW-1:0] REG_START_HDG = 3'd6;

    localparam logic [15:0] GAIN_UNITY = 16'd4096;

    localparam int CordicXW = 28;
    localparam int CordicZW = 26;
    localparam int AngleW   = CordicZW - 8;
    localparam int DiffW    = AngleW + 1;

    localparam logic signed [CordicZW-1:0] Z_HALF_TURN = 26'sd5898240;
    localparam logic signed [CordicZW-1:0] Z_ROUND     = 26'sd128;

    localparam logic signed [DiffW-1:0] WRAP_LIMIT = 19'sd23040;
    localparam logic signed [DiffW-1:0] WRAP_SPAN  = 19'sd46080;

    localparam logic signed [15:0] HEADING_MAX = 16'sd23040;
    localparam logic signed [15:0] HEADING_MIN = -16'sd23040;

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -24'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    // atan(2^-i) in units of 2^-15 degree
    function automatic logic signed [CordicZW-1:0] atan_step(input logic [4:0] i);
        logic signed [CordicZW-1:0] r;
        case (i)
            5'd0:    r = 26'sd1474560;
            5'd1:    r = 26'sd870484;
            5'd2:    r = 26'sd459940;
            5'd3:    r = 26'sd233473;
            5'd4:    r = 26'sd117189;
            5'd5:    r = 26'sd58652;
            5'd6:    r = 26'sd29333;
            5'd7:    r = 26'sd14667;
            5'd8:    r = 26'sd7334;
            5'd9:    r = 26'sd3667;
            5'd10:   r = 26'sd1833;
            5'd11:   r = 26'sd917;
            5'd12:   r = 26'sd458;
            5'd13:   r = 26'sd229;
            5'd14:   r = 26'sd115;
            5'd15:   r = 26'sd57;
            5'd16:   r = 26'sd29;
            5'd17:   r = 26'sd14;
            5'd18:   r = 26'sd7;
            5'd19:   r = 26'sd4;
            5'd20:   r = 26'sd2;
            5'd21:   r = 26'sd1;
            default: r = 26'sd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/chfc_axis_cal.sv
module chfc_axis_cal (
    input  logic               clk,
    input  logic [2:0]         en,
    input  logic signed [15:0] raw,
    input  logic signed [16:0] offset_half,
    input  logic [15:0]        gain,
    output logic signed [15:0] cal
);

    logic signed [18:0] diff_wide;
    logic signed [18:0] sum_wide;
    logic signed [15:0] field_next;
    logic signed [15:0] field_reg;
    logic signed [32:0] prod_next;
    logic signed [32:0] prod_reg;
    logic signed [32:0] round_wide;
    logic signed [15:0] cal_next;
    logic signed [15:0] cal_reg;

    always_comb
    begin
        diff_wide  = {{2{raw[15]}}, raw, 1'b0} - {{2{offset_half[16]}}, offset_half};
        sum_wide   = diff_wide + {18'd0, diff_wide[18]};
        field_next = chfc_pkg::sat16(24'(sum_wide >>> 1));
        prod_next  = field_reg * $signed({1'b0, gain});
        round_wide = prod_reg + (prod_reg[32] ? 33'sd4095 : 33'sd0);
        cal_next   = chfc_pkg::sat16(24'(round_wide >>> 12));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            field_reg <= field_next;
        end
        if (en[1])
        begin
            prod_reg <= prod_next;
        end
        if (en[2])
        begin
            cal_reg <= cal_next;
        end
    end

    assign cal = cal_reg;

endmodule

>>> rtl/chfc_cordic.sv
module chfc_cordic #(
    parameter int STEPS = 16
) (
    input  logic                                 clk,
    input  logic [STEPS:0]                       en,
    input  logic signed [15:0]                   cal_x_in,
    input  logic signed [15:0]                   cal_y_in,
    input  logic signed [15:0]                   cal_z_in,
    output logic signed [chfc_pkg::CordicZW-1:0] angle,
    output logic                                 zero_vec,
    output logic signed [15:0]                   cal_x_out,
    output logic signed [15:0]                   cal_y_out,
    output logic signed [15:0]                   cal_z_out
);

    localparam int XW = chfc_pkg::CordicXW;
    localparam int ZW = chfc_pkg::CordicZW;

    logic signed [XW-1:0] x_reg [0:STEPS];
    logic signed [XW-1:0] y_reg [0:STEPS];
    logic signed [ZW-1:0] z_reg [0:STEPS];
    logic                 zero_reg [0:STEPS];
    logic signed [15:0]   cx_reg [0:STEPS];
    logic signed [15:0]   cy_reg [0:STEPS];
    logic signed [15:0]   cz_reg [0:STEPS];

    logic signed [XW-1:0] xs_scaled;
    logic signed [XW-1:0] ys_scaled;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;
    logic signed [ZW-1:0] z_next;

    // fold the left half plane onto the right one
    always_comb
    begin
        xs_scaled = {{(XW-24){cal_y_in[15]}}, cal_y_in, 8'h00};
        ys_scaled = {{(XW-24){cal_x_in[15]}}, cal_x_in, 8'h00};
        if (cal_y_in[15])
        begin
            x_next = -xs_scaled;
            y_next = -ys_scaled;
            z_next = cal_x_in[15] ? -chfc_pkg::Z_HALF_TURN : chfc_pkg::Z_HALF_TURN;
        end
        else
        begin
            x_next = xs_scaled;
            y_next = ys_scaled;
            z_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            zero_reg[0] <= (cal_x_in == 16'sd0) && (cal_y_in == 16'sd0);
            cx_reg[0]   <= cal_x_in;
            cy_reg[0]   <= cal_y_in;
            cz_reg[0]   <= cal_z_in;
        end
    end

    for (genvar g = 1; g <= STEPS; g++)
    begin : g_step
        logic signed [XW-1:0] x_shift;
        logic signed [XW-1:0] y_shift;
        logic signed [ZW-1:0] atan_val;
        logic signed [XW-1:0] x_step;
        logic signed [XW-1:0] y_step;
        logic signed [ZW-1:0] z_step;

        always_comb
        begin
            x_shift  = x_reg[g-1] >>> (g - 1);
            y_shift  = y_reg[g-1] >>> (g - 1);
            atan_val = chfc_pkg::atan_step(5'(g - 1));
            if (!y_reg[g-1][XW-1])
            begin
                x_step = x_reg[g-1] + y_shift;
                y_step = y_reg[g-1] - x_shift;
                z_step = z_reg[g-1] + atan_val;
            end
            else
            begin
                x_step = x_reg[g-1] - y_shift;
                y_step = y_reg[g-1] + x_shift;
                z_step = z_reg[g-1] - atan_val;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                x_reg[g]    <= x_step;
                y_reg[g]    <= y_step;
                z_reg[g]    <= z_step;
                zero_reg[g] <= zero_reg[g-1];
                cx_reg[g]   <= cx_reg[g-1];
                cy_reg[g]   <= cy_reg[g-1];
                cz_reg[g]   <= cz_reg[g-1];
            end
        end
    end

    assign angle     = z_reg[STEPS];
    assign zero_vec  = zero_reg[STEPS];
    assign cal_x_out = cx_reg[STEPS];
    assign cal_y_out = cy_reg[STEPS];
    assign cal_z_out = cz_reg[STEPS];

endmodule

>>> rtl/compass_heading_from_calibrated_field.sv
// Channel   Direction  Handshake                   Payload
// sample    in         sample_valid/sample_stall   raw_x, raw_y, raw_z
// result    out        result_valid/result_stall   heading, cal_x, cal_y, cal_z
// config    in         cfg_we                      cfg_index, cfg_data
//
// One request per cycle while the result side does not stall; three calibration
// stages, one quadrant stage, one stage per CORDIC iteration, three heading stages.
// Reset clears all valid bits and loads the register defaults.
// A result stall holds each full stage that has no empty stage after it; bubbles
// still advance, and sample_stall rises only when every stage holds a request.
`include "compass_heading_from_calibrated_field_defines.svh"

module compass_heading_from_calibrated_field #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [15:0]                  raw_x,
    input  logic signed [15:0]                  raw_y,
    input  logic signed [15:0]                  raw_z,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [15:0]                  heading,
    output logic signed [15:0]                  cal_x,
    output logic signed [15:0]                  cal_y,
    output logic signed [15:0]                  cal_z,
    input  logic                                cfg_we,
    input  logic [chfc_pkg::CfgIndexW-1:0]      cfg_index,
    input  logic [chfc_pkg::CfgDataW-1:0]       cfg_data
);

    localparam int DEPTH  = CORDIC_STEPS + 7;
    localparam int CS0    = 3;
    localparam int FS0    = CS0 + CORDIC_STEPS + 1;
    localparam int ZW     = chfc_pkg::CordicZW;
    localparam int AW     = chfc_pkg::AngleW;
    localparam int DW     = chfc_pkg::DiffW;

    logic signed [16:0] offset_x_half_reg;
    logic signed [16:0] offset_y_half_reg;
    logic signed [16:0] offset_z_half_reg;
    logic [15:0]        gain_x_reg;
    logic [15:0]        gain_y_reg;
    logic [15:0]        gain_z_reg;
    logic signed [15:0] start_heading_reg;

    logic [DEPTH-1:0]   valid_reg;
    logic [DEPTH-1:0]   valid_next;
    logic [DEPTH:0]     adv;

    logic signed [15:0]   axis_x;
    logic signed [15:0]   axis_y;
    logic signed [15:0]   axis_z;
    logic signed [ZW-1:0] cordic_angle;
    logic                 cordic_zero;
    logic signed [15:0]   cordic_cx;
    logic signed [15:0]   cordic_cy;
    logic signed [15:0]   cordic_cz;

    logic signed [ZW-1:0] round_sum;
    logic signed [AW-1:0] angle_next;
    logic signed [AW-1:0] angle_reg;
    logic signed [DW-1:0] diff_next;
    logic signed [DW-1:0] diff_reg;
    logic signed [DW-1:0] wrap_lo;
    logic signed [DW-1:0] wrap_hi;
    logic signed [15:0]   heading_reg;
    logic signed [15:0]   cx_reg [0:2];
    logic signed [15:0]   cy_reg [0:2];
    logic signed [15:0]   cz_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_half_reg <= '0;
            offset_y_half_reg <= '0;
            offset_z_half_reg <= '0;
            gain_x_reg        <= chfc_pkg::GAIN_UNITY;
            gain_y_reg        <= chfc_pkg::GAIN_UNITY;
            gain_z_reg        <= chfc_pkg::GAIN_UNITY;
            start_heading_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                chfc_pkg::REG_OFFSET_X:  offset_x_half_reg <= cfg_data;
                chfc_pkg::REG_OFFSET_Y:  offset_y_half_reg <= cfg_data;
                chfc_pkg::REG_OFFSET_Z:  offset_z_half_reg <= cfg_data;
                chfc_pkg::REG_GAIN_X:    gain_x_reg        <= cfg_data[15:0];
                chfc_pkg::REG_GAIN_Y:    gain_y_reg        <= cfg_data[15:0];
                chfc_pkg::REG_GAIN_Z:    gain_z_reg        <= cfg_data[15:0];
                chfc_pkg::REG_START_HDG: start_heading_reg <= cfg_data[15:0];
                default:                 ;
            endcase
        end
    end

    // a stage advances when it is empty or the one after it advances
    always_comb
    begin
        adv[DEPTH] = !result_stall;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next = {valid_reg[DEPTH-2:0], sample_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    assign sample_stall = !adv[0];

    chfc_axis_cal u_cal_x (
        .clk         (clk),
        .en          (adv[2:0]),
        .raw         (raw_x),
        .offset_half (offset_x_half_reg),
        .gain        (gain_x_reg),
        .cal         (axis_x)
    );

    chfc_axis_cal u_cal_y (
        .clk         (clk),
        .en          (adv[2:0]),
        .raw         (raw_y),
        .offset_half (offset_y_half_reg),
        .gain        (gain_y_reg),
        .cal         (axis_y)
    );

    chfc_axis_cal u_cal_z (
        .clk         (clk),
        .en          (adv[2:0]),
        .raw         (raw_z),
        .offset_half (offset_z_half_reg),
        .gain        (gain_z_reg),
        .cal         (axis_z)
    );

    chfc_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .en        (adv[FS0-1:CS0]),
        .cal_x_in  (axis_x),
        .cal_y_in  (axis_y),
        .cal_z_in  (axis_z),
        .angle     (cordic_angle),
        .zero_vec  (cordic_zero),
        .cal_x_out (cordic_cx),
        .cal_y_out (cordic_cy),
        .cal_z_out (cordic_cz)
    );

    always_comb
    begin
        round_sum  = cordic_angle + chfc_pkg::Z_ROUND;
        angle_next = cordic_zero ? '0 : round_sum[ZW-1:8];
        diff_next  = {angle_reg[AW-1], angle_reg}
                   - {{(DW-16){start_heading_reg[15]}}, start_heading_reg};
        wrap_lo    = (diff_reg < -chfc_pkg::WRAP_LIMIT) ? diff_reg + chfc_pkg::WRAP_SPAN
                                                        : diff_reg;
        wrap_hi    = (wrap_lo > chfc_pkg::WRAP_LIMIT) ? wrap_lo - chfc_pkg::WRAP_SPAN
                                                      : wrap_lo;
    end

    always_ff @(posedge clk)
    begin
        if (adv[FS0])
        begin
            angle_reg <= angle_next;
            cx_reg[0] <= cordic_cx;
            cy_reg[0] <= cordic_cy;
            cz_reg[0] <= cordic_cz;
        end
        if (adv[FS0+1])
        begin
            diff_reg  <= diff_next;
            cx_reg[1] <= cx_reg[0];
            cy_reg[1] <= cy_reg[0];
            cz_reg[1] <= cz_reg[0];
        end
        if (adv[FS0+2])
        begin
            heading_reg <= wrap_hi[15:0];
            cx_reg[2]   <= cx_reg[1];
            cy_reg[2]   <= cy_reg[1];
            cz_reg[2]   <= cz_reg[1];
        end
    end

    assign result_valid = valid_reg[DEPTH-1];
    assign heading      = heading_reg;
    assign cal_x        = cx_reg[2];
    assign cal_y        = cy_reg[2];
    assign cal_z        = cz_reg[2];

    `CHFC_ASSERT_IMPLY(a_heading_range, result_valid, (heading <= chfc_pkg::HEADING_MAX) && (heading >= chfc_pkg::HEADING_MIN), "heading outside wrap range")
    `CHFC_ASSERT_IMPLY(a_stall_only_full, sample_stall, (valid_reg == {DEPTH{1'b1}}) && result_stall, "input stalled with room in pipeline")

endmodule

>>> bench/compass_heading_from_calibrated_field_test.sv
module compass_heading_from_calibrated_field_test;

    localparam int CORDIC_STEPS = 16;
    localparam int CfgIndexW = chfc_pkg::CfgIndexW;
    localparam int CfgDataW  = chfc_pkg::CfgDataW;
    localparam logic [CfgIndexW-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [15:0] heading;
        logic signed [15:0] cal_x;
        logic signed [15:0] cal_y;
        logic signed [15:0] cal_z;
    } compass_result_t;

    class heading_scoreboard_t;
        longint offset_half [3];
        longint gain [3];
        longint start_hdg;
        compass_result_t expected_q [$];
        int errors;

        function new();
            foreach (offset_half[i])
            begin
                offset_half[i] = 0;
                gain[i] = 4096;
            end
            start_hdg = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                chfc_pkg::REG_OFFSET_X:  offset_half[0] = longint'($signed(data));
                chfc_pkg::REG_OFFSET_Y:  offset_half[1] = longint'($signed(data));
                chfc_pkg::REG_OFFSET_Z:  offset_half[2] = longint'($signed(data));
                chfc_pkg::REG_GAIN_X:    gain[0] = longint'(data[15:0]);
                chfc_pkg::REG_GAIN_Y:    gain[1] = longint'(data[15:0]);
                chfc_pkg::REG_GAIN_Z:    gain[2] = longint'(data[15:0]);
                chfc_pkg::REG_START_HDG: start_hdg = longint'($signed(data[15:0]));
                default: ;
            endcase
        endfunction

        function longint clamp16(longint v);
            if (v > 32767)
            begin
                return 32767;
            end
            if (v < -32768)
            begin
                return -32768;
            end
            return v;
        endfunction

        function longint calibrate(longint raw, longint off, longint g);
            longint d;
            d = clamp16((2 * raw - off) / 2);
            return clamp16((d * g) / 4096);
        endfunction

        function longint arc_of(int i);
            case (i)
                0:  return 1474560;
                1:  return 870484;
                2:  return 459940;
                3:  return 233473;
                4:  return 117189;
                5:  return 58652;
                6:  return 29333;
                7:  return 14667;
                8:  return 7334;
                9:  return 3667;
                10: return 1833;
                11: return 917;
                12: return 458;
                13: return 229;
                14: return 115;
                15: return 57;
                16: return 29;
                17: return 14;
                18: return 7;
                19: return 4;
                20: return 2;
                21: return 1;
                default: return 0;
            endcase
        endfunction

        // angle of (north, east) measured toward east, in 1/128 degree
        function longint bearing(longint east, longint north);
            longint u;
            longint v;
            longint acc;
            longint nu;
            int i;
            if (east == 0 && north == 0)
            begin
                return 0;
            end
            u = north * 256;
            v = east * 256;
            acc = 0;
            if (u < 0)
            begin
                acc = (east >= 0) ? 180 * 32768 : -180 * 32768;
                u = -u;
                v = -v;
            end
            for (i = 0; i < CORDIC_STEPS && i < 24; i++)
            begin
                if (v >= 0)
                begin
                    nu = u + (v >>> i);
                    v = v - (u >>> i);
                    acc += arc_of(i);
                end
                else
                begin
                    nu = u - (v >>> i);
                    v = v + (u >>> i);
                    acc -= arc_of(i);
                end
                u = nu;
            end
            return (acc + 128) >>> 8;
        endfunction

        function void note_sample(logic signed [15:0] x, logic signed [15:0] y,
                                  logic signed [15:0] z);
            compass_result_t r;
            longint cx;
            longint cy;
            longint cz;
            longint h;
            cx = calibrate(longint'(x), offset_half[0], gain[0]);
            cy = calibrate(longint'(y), offset_half[1], gain[1]);
            cz = calibrate(longint'(z), offset_half[2], gain[2]);
            h = bearing(cx, cy) - start_hdg;
            if (h < -23040)
            begin
                h += 46080;
            end
            if (h > 23040)
            begin
                h -= 46080;
            end
            r.heading = 16'(h);
            r.cal_x = 16'(cx);
            r.cal_y = 16'(cy);
            r.cal_z = 16'(cz);
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [15:0] want,
                                    logic signed [15:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic signed [15:0] h, logic signed [15:0] x,
                                   logic signed [15:0] y, logic signed [15:0] z);
            compass_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none, got %0d %0d %0d %0d",
                         $time, h, x, y, z);
                return;
            end
            want = expected_q.pop_front();
            compare_field("heading", want.heading, h);
            compare_field("cal_x", want.cal_x, x);
            compare_field("cal_y", want.cal_y, y);
            compare_field("cal_z", want.cal_z, z);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_stall;
    logic signed [15:0] raw_x = '0;
    logic signed [15:0] raw_y = '0;
    logic signed [15:0] raw_z = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [15:0] heading;
    logic signed [15:0] cal_x;
    logic signed [15:0] cal_y;
    logic signed [15:0] cal_z;
    logic cfg_we = 1'b0;
    logic [CfgIndexW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    int idle_pct = 0;
    int stall_pct = 0;

    heading_scoreboard_t board = new();

    compass_heading_from_calibrated_field #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .raw_x(raw_x),
        .raw_y(raw_y),
        .raw_z(raw_z),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .heading(heading),
        .cal_x(cal_x),
        .cal_y(cal_y),
        .cal_z(cal_z),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                board.check_result(heading, cal_x, cal_y, cal_z);
            end
            result_stall <= rst_n && ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic signed [15:0] z);
        while ($urandom_range(99) < idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        raw_x <= x;
        raw_y <= y;
        raw_z <= z;
        @(posedge clk);
        while (sample_stall)
        begin
            @(posedge clk);
        end
        board.note_sample(x, y, z);
    endtask

    task automatic program_reg(input logic [CfgIndexW-1:0] idx,
                               input logic [CfgDataW-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (CORDIC_STEPS + 12) @(posedge clk);
    endtask

    function automatic logic [CfgDataW-1:0] pick_offset();
        if ($urandom_range(1) == 0)
        begin
            return CfgDataW'($urandom);
        end
        return CfgDataW'(int'($urandom_range(8000)) - 4000);
    endfunction

    function automatic logic [CfgDataW-1:0] pick_gain();
        if ($urandom_range(3) == 0)
        begin
            return CfgDataW'($urandom);
        end
        return CfgDataW'($urandom_range(12288, 1024));
    endfunction

    function automatic logic signed [15:0] pick_raw();
        case ($urandom_range(5))
            0, 1:    return 16'($urandom);
            2:       return 16'(int'($urandom_range(4000)) - 2000);
            3:       return 16'(int'($urandom_range(6)) - 3);
            4:       return 16'(int'($urandom_range(400)) - 200);
            default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    task automatic configure(input int kind);
        logic [CfgDataW-1:0] off [3];
        logic [CfgDataW-1:0] g [3];
        logic [CfgDataW-1:0] start;
        int i;
        for (i = 0; i < 3; i++)
        begin
            off[i] = pick_offset();
            g[i] = pick_gain();
        end
        start = CfgDataW'(int'($urandom_range(46080)) - 23040);
        case (kind)
            0:
            begin
                off = '{default: '0};
                g = '{default: CfgDataW'(chfc_pkg::GAIN_UNITY)};
                start = '0;
            end
            1:
            begin
                off = '{default: 17'h0ffff};
                g = '{default: 17'h1ffff};
                start = CfgDataW'(chfc_pkg::HEADING_MAX);
            end
            2:
            begin
                off = '{default: 17'h10000};
                g[0] = '0;
                g[1] = 17'h0ffff;
                g[2] = '0;
                start = CfgDataW'(chfc_pkg::HEADING_MIN);
            end
            3:
            begin
                start = 17'h08000;
            end
            4:
            begin
                start = 17'h07fff;
            end
            default: ;
        endcase
        program_reg(chfc_pkg::REG_OFFSET_X, off[0]);
        program_reg(chfc_pkg::REG_OFFSET_Y, off[1]);
        program_reg(chfc_pkg::REG_OFFSET_Z, off[2]);
        program_reg(chfc_pkg::REG_GAIN_X, g[0]);
        program_reg(chfc_pkg::REG_GAIN_Y, g[1]);
        program_reg(chfc_pkg::REG_GAIN_Z, g[2]);
        program_reg(chfc_pkg::REG_START_HDG, start);
        if (kind == 2)
        begin
            program_reg(REG_UNUSED, CfgDataW'($urandom));
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int phase;
        int n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh8000, 16'sd0);
        send_sample(16'sh8000, 16'sh7fff, 16'sd0);
        send_sample(16'sd1, 16'sd0, 16'sd5);
        send_sample(-16'sd1, 16'sd0, -16'sd5);
        send_sample(16'sd0, 16'sd1, 16'sd0);
        send_sample(16'sd0, -16'sd1, 16'sd0);
        send_sample(-16'sd1, -16'sd1, 16'sd0);
        send_sample(16'sd1, -16'sd1, 16'sd0);
        send_sample(16'sd1, 16'sd1, 16'sd1);
        send_sample(-16'sd7, 16'sd3, 16'sd100);
        send_sample(16'sd100, -16'sd100, -16'sd100);
        send_sample(16'sh8000, 16'sd0, 16'sh7fff);

        for (phase = 0; phase < 10; phase++)
        begin
            sample_valid <= 1'b0;
            wait_drained();
            configure(phase);
            case (phase % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 63;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 63;
                end
                default:
                begin
                    idle_pct = 36;
                    stall_pct = 36;
                end
            endcase
            for (n = 0; n < 75; n++)
            begin
                send_sample(pick_raw(), pick_raw(), pick_raw());
            end
        end
        sample_valid <= 1'b0;
        wait_drained();

        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
